>>> design/sfmp_pkg.sv
// Shared types and constants for the symbolic file mode parser.
package sfmp_pkg;

    localparam int BUFFER_BYTES = 256;
    localparam int COUNT_W      = $clog2(BUFFER_BYTES + 1);

    localparam logic [11:0] MODE_MASK = 12'o7777;
    localparam logic [12:0] OCTAL_SAT = 13'o10000;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_INVALID  = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    typedef enum logic [4:0] {
        K_OCT,
        K_DEC_HI,
        K_U,
        K_G,
        K_O,
        K_A,
        K_PLUS,
        K_MINUS,
        K_EQ,
        K_R,
        K_W,
        K_X,
        K_BIGX,
        K_S,
        K_T,
        K_COMMA,
        K_OTHER
    } kind_t;

    typedef struct packed {
        logic [7:0]  char_code;
        logic        last_char;
        logic [11:0] file_mode;
        logic        is_directory;
    } char_item_t;

    typedef struct packed {
        logic [11:0] result_mode;
        logic [1:0]  status;
    } result_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  digit;
        logic        last_char;
        logic [11:0] file_mode;
        logic        is_directory;
    } token_t;

endpackage

>>> design/sfmp_front.sv
// Front end: classify each incoming character into a token for the queue.
module sfmp_front (
    input  logic                char_valid,
    input  sfmp_pkg::char_item_t char_item,
    input  logic                q_full,
    output logic                char_stall,
    output logic                push,
    output sfmp_pkg::token_t    token
);

    sfmp_pkg::kind_t kind;

    always_comb
    begin
        unique case (char_item.char_code) inside
            [8'h30:8'h37]:              kind = sfmp_pkg::K_OCT;
            8'h38, 8'h39:               kind = sfmp_pkg::K_DEC_HI;
            8'h75:                      kind = sfmp_pkg::K_U;      // u
            8'h67:                      kind = sfmp_pkg::K_G;      // g
            8'h6f:                      kind = sfmp_pkg::K_O;      // o
            8'h61:                      kind = sfmp_pkg::K_A;      // a
            8'h2b:                      kind = sfmp_pkg::K_PLUS;
            8'h2d:                      kind = sfmp_pkg::K_MINUS;
            8'h3d:                      kind = sfmp_pkg::K_EQ;
            8'h72:                      kind = sfmp_pkg::K_R;      // r
            8'h77:                      kind = sfmp_pkg::K_W;      // w
            8'h78:                      kind = sfmp_pkg::K_X;      // x
            8'h58:                      kind = sfmp_pkg::K_BIGX;   // X
            8'h73:                      kind = sfmp_pkg::K_S;      // s
            8'h74:                      kind = sfmp_pkg::K_T;      // t
            8'h2c:                      kind = sfmp_pkg::K_COMMA;
            default:                    kind = sfmp_pkg::K_OTHER;
        endcase
    end

    assign token.kind         = kind;
    assign token.digit        = char_item.char_code[2:0];
    assign token.last_char    = char_item.last_char;
    assign token.file_mode    = char_item.file_mode;
    assign token.is_directory = char_item.is_directory;

    assign char_stall = q_full;
    assign push       = char_valid & ~q_full;

endmodule

>>> design/sfmp_queue.sv
// Two-entry token queue between the front end and the parser.
module sfmp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sfmp_pkg::token_t push_token,
    input  logic             pop,
    output logic             full,
    output logic             q_valid,
    output sfmp_pkg::token_t q_token
);

    sfmp_pkg::token_t entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_token = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

>>> design/sfmp_back.sv
// Back end: run the mode string parser on each token and register the result.
module sfmp_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  sfmp_pkg::token_t       q_token,
    output logic                   pop,
    input  logic                   result_stall,
    output logic                   result_valid,
    output sfmp_pkg::result_item_t result_item
);

    typedef enum logic [2:0] {
        PH_START,
        PH_CLAUSE,
        PH_WHO,
        PH_PERM,
        PH_OCTAL,
        PH_BAD
    } phase_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_SET
    } op_t;

    function automatic logic [11:0] spread(input logic [2:0] trio, input logic [2:0] who);
        spread = {3'b000, who[2] ? trio : 3'b000, who[1] ? trio : 3'b000,
                  who[0] ? trio : 3'b000};
    endfunction

    phase_t                        phase_reg, phase_next;
    logic [11:0]                   mode_reg, mode_next;
    logic [2:0]                    who_reg, who_next;
    op_t                           op_reg, op_next;
    logic [11:0]                   change_reg, change_next;
    logic [12:0]                   octal_reg, octal_next;
    logic [sfmp_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic                          dir_reg, dir_next;
    logic                          out_valid_reg, out_valid_next;
    sfmp_pkg::result_item_t        out_item_reg, out_item_next;

    logic                          start;
    logic [11:0]                   base_mode;
    logic                          base_dir;
    logic [2:0]                    who_work;
    op_t                           op_work;
    logic [11:0]                   change_work;
    logic [12:0]                   octal_cur;
    logic [15:0]                   octal_sum;
    logic [sfmp_pkg::COUNT_W-1:0]  count_cur;
    phase_t                        phase_in, phase_work;
    logic [11:0]                   clr_bits;
    logic [11:0]                   applied;
    logic                          too_long;

    assign pop = q_valid & (~q_token.last_char | ~out_valid_reg | ~result_stall);

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    always_comb
    begin
        start     = (phase_reg == PH_START);
        base_mode = start ? q_token.file_mode : mode_reg;
        base_dir  = start ? q_token.is_directory : dir_reg;
        who_work  = start ? 3'b000 : who_reg;
        op_work   = start ? OP_ADD : op_reg;
        change_work = start ? 12'd0 : change_reg;
        octal_cur = start ? 13'd0 : octal_reg;
        count_cur = start ? '0 : count_reg;
        octal_sum = 16'd0;
        phase_in  = phase_reg;
        phase_work = phase_reg;

        // The first character picks octal or symbolic form
        if (start)
        begin
            if (q_token.kind == sfmp_pkg::K_OCT || q_token.kind == sfmp_pkg::K_DEC_HI)
            begin
                phase_in = PH_OCTAL;
            end
            else
            begin
                phase_in = PH_CLAUSE;
            end
        end

        unique case (phase_in) inside
            PH_OCTAL:
            begin
                if (q_token.kind == sfmp_pkg::K_OCT)
                begin
                    octal_sum = {octal_cur, 3'b000} + {13'd0, q_token.digit};
                    if (octal_sum > {3'b000, sfmp_pkg::OCTAL_SAT})
                    begin
                        octal_cur = sfmp_pkg::OCTAL_SAT;
                    end
                    else
                    begin
                        octal_cur = octal_sum[12:0];
                    end
                    phase_work = PH_OCTAL;
                end
                else
                begin
                    phase_work = PH_BAD;
                end
            end
            PH_CLAUSE, PH_WHO:
            begin
                case (q_token.kind) inside
                    sfmp_pkg::K_U:
                    begin
                        who_work   = who_work | 3'b100;
                        phase_work = PH_WHO;
                    end
                    sfmp_pkg::K_G:
                    begin
                        who_work   = who_work | 3'b010;
                        phase_work = PH_WHO;
                    end
                    sfmp_pkg::K_O:
                    begin
                        who_work   = who_work | 3'b001;
                        phase_work = PH_WHO;
                    end
                    sfmp_pkg::K_A:
                    begin
                        who_work   = 3'b111;
                        phase_work = PH_WHO;
                    end
                    sfmp_pkg::K_PLUS, sfmp_pkg::K_MINUS, sfmp_pkg::K_EQ:
                    begin
                        op_work = (q_token.kind == sfmp_pkg::K_PLUS)  ? OP_ADD :
                                  (q_token.kind == sfmp_pkg::K_MINUS) ? OP_SUB : OP_SET;
                        if (who_work == 3'b000)
                        begin
                            who_work = 3'b111;
                        end
                        change_work = 12'd0;
                        phase_work  = PH_PERM;
                    end
                    default:
                    begin
                        phase_work = PH_BAD;
                    end
                endcase
            end
            PH_PERM:
            begin
                case (q_token.kind)
                    sfmp_pkg::K_R:  change_work = change_work | spread(3'b100, who_work);
                    sfmp_pkg::K_W:  change_work = change_work | spread(3'b010, who_work);
                    sfmp_pkg::K_X:  change_work = change_work | spread(3'b001, who_work);
                    sfmp_pkg::K_BIGX:
                    begin
                        if (base_dir || (base_mode & 12'o0111) != 12'd0)
                        begin
                            change_work = change_work | spread(3'b001, who_work);
                        end
                    end
                    sfmp_pkg::K_S:
                    begin
                        change_work = change_work | {who_work[2], who_work[1], 10'd0};
                    end
                    sfmp_pkg::K_T:  change_work = change_work | 12'o1000;
                    sfmp_pkg::K_U:  change_work = change_work | spread(base_mode[8:6], who_work);
                    sfmp_pkg::K_G:  change_work = change_work | spread(base_mode[5:3], who_work);
                    sfmp_pkg::K_O:  change_work = change_work | spread(base_mode[2:0], who_work);
                    sfmp_pkg::K_COMMA: phase_work = PH_CLAUSE;
                    default:        phase_work = PH_BAD;
                endcase
            end
            default:
            begin
                phase_work = PH_BAD;
            end
        endcase

        // Apply the open clause to the running mode
        clr_bits = {who_work[2], who_work[1], who_work[0],
                    {3{who_work[2]}}, {3{who_work[1]}}, {3{who_work[0]}}};
        unique case (op_work)
            OP_ADD:  applied = base_mode | change_work;
            OP_SUB:  applied = base_mode & ~change_work;
            OP_SET:  applied = (base_mode & ~clr_bits) | change_work;
            default: applied = base_mode;
        endcase
        applied = applied & sfmp_pkg::MODE_MASK;

        if (count_cur < sfmp_pkg::COUNT_W'(sfmp_pkg::BUFFER_BYTES))
        begin
            count_next = count_cur + 1'b1;
        end
        else
        begin
            count_next = count_cur;
        end
        too_long = (count_next >= sfmp_pkg::COUNT_W'(sfmp_pkg::BUFFER_BYTES));

        mode_next   = base_mode;
        who_next    = who_work;
        op_next     = op_work;
        change_next = change_work;
        octal_next  = octal_cur;
        dir_next    = base_dir;
        phase_next  = phase_work;

        if (phase_in == PH_PERM && q_token.kind == sfmp_pkg::K_COMMA)
        begin
            mode_next   = applied;
            who_next    = 3'b000;
            op_next     = OP_ADD;
            change_next = 12'd0;
        end

        out_item_next.result_mode = 12'd0;
        out_item_next.status      = sfmp_pkg::STATUS_OK;
        if (too_long)
        begin
            out_item_next.status = sfmp_pkg::STATUS_TOO_LONG;
        end
        else if (phase_work == PH_OCTAL)
        begin
            if (octal_cur > {1'b0, sfmp_pkg::MODE_MASK})
            begin
                out_item_next.status = sfmp_pkg::STATUS_INVALID;
            end
            else
            begin
                out_item_next.result_mode = octal_cur[11:0];
            end
        end
        else if (phase_work == PH_PERM)
        begin
            out_item_next.result_mode = applied;
        end
        else if (phase_work == PH_CLAUSE)
        begin
            out_item_next.result_mode = mode_next;
        end
        else
        begin
            out_item_next.status = sfmp_pkg::STATUS_INVALID;
        end

        // End of string: emit and start over
        if (q_token.last_char)
        begin
            phase_next = PH_START;
        end

        if (pop && q_token.last_char)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            mode_reg      <= 12'd0;
            who_reg       <= 3'b000;
            op_reg        <= OP_ADD;
            change_reg    <= 12'd0;
            octal_reg     <= 13'd0;
            count_reg     <= '0;
            dir_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg  <= phase_next;
                mode_reg   <= mode_next;
                who_reg    <= who_next;
                op_reg     <= op_next;
                change_reg <= change_next;
                octal_reg  <= octal_next;
                count_reg  <= count_next;
                dir_reg    <= dir_next;
            end
            if (pop && q_token.last_char)
            begin
                out_item_reg <= out_item_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> design/symbolic_file_mode_parser.sv
// Symbolic and octal file mode parser: evaluates a mode string one character at a time.
//
// The char channel carries one character per transaction; the first character of a
// string also brings the file's current mode and directory flag, and last_char marks
// the end of the string. The result channel carries one transaction per string, the
// new mode and a status (ok, invalid mode, string too long), sent after the last
// character. Characters that are not last give no result.
//
// One character is taken per cycle while the queue has room. A character goes through
// the classifier into a two-entry queue, and the parser takes one token a cycle from it
// unless a last character waits on a stalled result; the result of a string is in the
// output register in the cycle after the parser takes its last character.
//
// When the receiver stalls, the result holds in the output register; the parser keeps
// going through non-final characters and waits only on a final one, and the char side
// stalls once the queue is full. Reset empties the queue, drops any pending result and
// leaves the parser at the start of a string.
module symbolic_file_mode_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   char_valid,
    output logic                   char_stall,
    input  sfmp_pkg::char_item_t   char_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output sfmp_pkg::result_item_t result_item
);

    logic             q_full;
    logic             push;
    logic             pop;
    logic             q_valid;
    sfmp_pkg::token_t push_token;
    sfmp_pkg::token_t q_token;

    sfmp_front u_front (
        .char_valid (char_valid),
        .char_item  (char_item),
        .q_full     (q_full),
        .char_stall (char_stall),
        .push       (push),
        .token      (push_token)
    );

    sfmp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .pop        (pop),
        .full       (q_full),
        .q_valid    (q_valid),
        .q_token    (q_token)
    );

    sfmp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_token      (q_token),
        .pop          (pop),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result_item  (result_item)
    );

endmodule
